// File: rtl/sha_pkg.sv
`default_nettype none
package sha_pkg;

	localparam int WordW = 32;

	typedef logic [WordW-1:0] word_t;

	// Initial hash values
	function automatic word_t iv(input logic [2:0] i);
		word_t r;
		begin
			unique case (i)
				3'd0: r = 32'h6A09E667;
				3'd1: r = 32'hBB67AE85;
				3'd2: r = 32'h3C6EF372;
				3'd3: r = 32'hA54FF53A;
				3'd4: r = 32'h510E527F;
				3'd5: r = 32'h9B05688C;
				3'd6: r = 32'h1F83D9AB;
				default: r = 32'h5BE0CD19;
			endcase
			return r;
		end
	endfunction

	// Round constants
	function automatic word_t rc(input logic [5:0] i);
		word_t k [64];
		begin
			k = '{
				32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
				32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
				32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
				32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
				32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
				32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
				32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
				32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
				32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
				32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
				32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
				32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
				32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
				32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
				32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
				32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
			return k[i];
		end
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	// Controller states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LEN   = 6'b000100,
		ST_RND   = 6'b001000,
		ST_FOLD  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	// Request from controller to compression core
	typedef struct packed {
		logic start;
		logic init;
	} core_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

endpackage
`default_nettype wire

// File: rtl/sha_core.sv
`default_nettype none
// 64-round compression. Message schedule is a 16-entry shift window:
// w[t] is at index 0 when round t runs. Hash words live in an 8-entry memory read per lane.
module sha_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire sha_pkg::core_req_t req,
	output sha_pkg::core_sts_t sts,
	// chunk buffer write port from controller
	input  wire               bw_en,
	input  wire  [3:0]        bw_addr,
	input  wire sha_pkg::word_t bw_data,
	// digest read port
	input  wire  [2:0]        hr_addr,
	output sha_pkg::word_t    hr_data
);
	sha_pkg::word_t buf_mem [16];
	sha_pkg::word_t hash_mem [8];
	sha_pkg::word_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	sha_pkg::word_t w_q [16];
	logic [6:0] cnt_q;
	logic       run_q, fold_q, load_q;
	logic [2:0] fi_q;
	logic       init_q;
	logic [2:0] ii_q;

	// Chunk buffer: controller writes, core copies into schedule window on start
	always_ff @(posedge clk) begin
		if (bw_en) buf_mem[bw_addr] <= bw_data;
	end

	// Schedule step
	sha_pkg::word_t wt, s0, s1, wn, t1, t2, bs0, bs1, ch, mj;
	always_comb begin
		wt  = w_q[0];
		s0  = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1  = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn  = s1 + w_q[9] + s0 + w_q[0];
		bs1 = sha_pkg::rotr(e_q, 6) ^ sha_pkg::rotr(e_q, 11) ^ sha_pkg::rotr(e_q, 25);
		ch  = (e_q & f_q) ^ (~e_q & g_q);
		t1  = h_q + bs1 + ch + sha_pkg::rc(cnt_q[5:0]) + wt;
		bs0 = sha_pkg::rotr(a_q, 2) ^ sha_pkg::rotr(a_q, 13) ^ sha_pkg::rotr(a_q, 22);
		mj  = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
		t2  = bs0 + mj;
	end

	// Hash memory: one read-modify-write per lane during fold, read port for digest
	sha_pkg::word_t hrd_q, fold_src;
	always_comb begin
		unique case (fi_q)
			3'd0: fold_src = a_q;
			3'd1: fold_src = b_q;
			3'd2: fold_src = c_q;
			3'd3: fold_src = d_q;
			3'd4: fold_src = e_q;
			3'd5: fold_src = f_q;
			3'd6: fold_src = g_q;
			default: fold_src = h_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (init_q) hash_mem[ii_q] <= sha_pkg::iv(ii_q);
		else if (fold_q) hash_mem[fi_q] <= hash_mem[fi_q] + fold_src;
		hrd_q <= hash_mem[hr_addr];
	end
	assign hr_data = hrd_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fold_q <= 1'b0;
			load_q <= 1'b0;
			cnt_q  <= '0;
			fi_q   <= '0;
			init_q <= 1'b1;
			ii_q   <= '0;
		end else begin
			if (req.init) begin
				init_q <= 1'b1;
				ii_q   <= '0;
			end else if (init_q) begin
				ii_q <= ii_q + 3'd1;
				if (ii_q == 3'd7) init_q <= 1'b0;
			end
			if (req.start) begin
				load_q <= 1'b1;
				cnt_q  <= '0;
			end else if (load_q) begin
				load_q <= (cnt_q != 7'd15);
				run_q  <= (cnt_q == 7'd15);
				cnt_q  <= (cnt_q == 7'd15) ? 7'd0 : cnt_q + 7'd1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					run_q  <= 1'b0;
					fold_q <= 1'b1;
					fi_q   <= '0;
				end
			end else if (fold_q) begin
				fi_q <= fi_q + 3'd1;
				if (fi_q == 3'd7) fold_q <= 1'b0;
			end
		end
	end

	// Load: shift buffer words and hash words into window and working vars
	always_ff @(posedge clk) begin
		if (load_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= buf_mem[cnt_q[3:0]];
			if (cnt_q[3:0] < 4'd8) begin
				{a_q, b_q, c_q, d_q, e_q, f_q, g_q} <= {b_q, c_q, d_q, e_q, f_q, g_q, h_q};
				h_q <= hash_mem[cnt_q[2:0]];
			end
		end else if (run_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	assign sts.busy = load_q | run_q | fold_q | init_q;
	assign sts.done = fold_q && (fi_q == 3'd7);
endmodule
`default_nettype wire

// File: rtl/sha256_hash_engine.sv
`default_nettype none
// Channel | Dir | Beat contents
// s_axis  | in  | tdata {byte_count, data_word}, 5 bytes; tlast = end_of_message
// m_axis  | out | tdata {word_index, digest_word}, 5 bytes; tlast = last_word
// A message word is taken as one beat; its valid bytes are then placed into the chunk buffer
// before the next beat is taken. A byte that fills the 64-byte chunk starts the core (load,
// rounds, fold), during which input is held. End of message: pad bytes one a cycle while
// the core is idle, then the two length words, the last compression, the fold and output
// states, and a registered hash memory read before each digest beat.
// Reset: the initial hash words are loaded into the hash memory, again after each digest.
// Output stalls hold the digest read; input is not taken until digest beats drain.
module sha256_hash_engine (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [39:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32]
	input  wire        s_axis_tlast,
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [39:0] m_axis_tdata, // digest_word[31:0], word_index[34:32]
	output logic       m_axis_tlast
);
	sha_pkg::state_t st_q;
	sha_pkg::core_req_t req;
	sha_pkg::core_sts_t sts;
	logic [5:0]  nb_q;       // bytes in chunk
	logic [63:0] bits_q;
	logic [31:0] word_q, acc_q;
	logic [2:0]  left_q;
	logic        eom_q, pad_q;
	logic [2:0]  oi_q;
	logic        ov_q;
	logic        bw_en;
	logic [3:0]  bw_addr;
	sha_pkg::word_t bw_data, hr_data;
	logic [7:0]  cur_byte;
	logic [2:0]  cnt_in;
	logic [2:0]  hr_addr;

	sha_core u_core (
		.clk, .arst_n, .req, .sts,
		.bw_en, .bw_addr, .bw_data, .hr_addr, .hr_data
	);

	assign cnt_in = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
	assign s_axis_tready = (st_q == sha_pkg::ST_IDLE) && !sts.busy && (left_q == 3'd0);
	// The first pad byte is 0x80, the rest are zero
	assign cur_byte = (st_q == sha_pkg::ST_PAD) ? (pad_q ? 8'h00 : 8'h80) : word_q[31:24];
	assign hr_addr = oi_q;

	// Byte packer: one byte per cycle into the chunk buffer while the core is not busy; length words in ST_LEN
	always_comb begin
		bw_en   = 1'b0;
		bw_addr = nb_q[5:2];
		bw_data = {acc_q[23:0], cur_byte};
		if (st_q == sha_pkg::ST_LEN) begin
			bw_en   = 1'b1;
			bw_addr = nb_q[5:2];
			bw_data = nb_q[2] ? bits_q[31:0] : bits_q[63:32];
		end else if ((left_q != 3'd0 || st_q == sha_pkg::ST_PAD) && !sts.busy) begin
			bw_en = 1'b1;
		end
	end

	assign req.start = bw_en && ((st_q == sha_pkg::ST_LEN) ? nb_q == 6'd60 :
		nb_q == 6'd63);
	assign req.init = (st_q == sha_pkg::ST_OUT) && ov_q && m_axis_tready && oi_q == 3'd7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= sha_pkg::ST_IDLE;
			nb_q   <= '0;
			bits_q <= '0;
			left_q <= '0;
			eom_q  <= 1'b0;
			pad_q  <= 1'b0;
			oi_q   <= '0;
			ov_q   <= 1'b0;
		end else begin
			// accept a beat
			if (s_axis_tvalid && s_axis_tready) begin
				left_q <= cnt_in;
				eom_q  <= s_axis_tlast;
				bits_q <= bits_q + {58'd0, cnt_in, 3'd0};
				if (cnt_in == 3'd0 && s_axis_tlast) begin
					st_q <= sha_pkg::ST_PAD;
					pad_q <= 1'b0;
				end
			end
			// place a message byte
			if (bw_en && st_q == sha_pkg::ST_IDLE) begin
				nb_q   <= nb_q + 6'd1;
				left_q <= left_q - 3'd1;
				if (left_q == 3'd1 && eom_q) begin
					st_q <= sha_pkg::ST_PAD;
					pad_q <= 1'b0;
				end
			end
			unique case (st_q)
				sha_pkg::ST_PAD: if (bw_en) begin
					nb_q  <= nb_q + 6'd1;
					pad_q <= 1'b1;
					if (nb_q == 6'd55) st_q <= sha_pkg::ST_LEN;
				end
				sha_pkg::ST_LEN: begin
					nb_q <= nb_q + 6'd4;
					if (nb_q == 6'd60) st_q <= sha_pkg::ST_RND;
				end
				sha_pkg::ST_RND: if (sts.done) st_q <= sha_pkg::ST_FOLD;
				sha_pkg::ST_FOLD: begin
					st_q <= sha_pkg::ST_OUT;
					oi_q <= '0;
					ov_q <= 1'b0;
				end
				sha_pkg::ST_OUT: begin
					if (!ov_q) ov_q <= 1'b1;
					else if (m_axis_tready) begin
						oi_q <= oi_q + 3'd1;
						ov_q <= 1'b0;
						if (oi_q == 3'd7) begin
							st_q   <= sha_pkg::ST_IDLE;
							bits_q <= '0;
							nb_q   <= '0;
							eom_q  <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Shift register for the current word and the byte accumulator
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) word_q <= s_axis_tdata[31:0];
		else if (bw_en && st_q == sha_pkg::ST_IDLE) word_q <= {word_q[23:0], 8'h00};
		if (bw_en && st_q != sha_pkg::ST_LEN) acc_q <= nb_q[1:0] == 2'd3 ? 32'd0 : bw_data;
	end

	assign m_axis_tvalid = (st_q == sha_pkg::ST_OUT) && ov_q;
	assign m_axis_tdata  = {5'd0, oi_q, hr_data};
	assign m_axis_tlast  = (oi_q == 3'd7);

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("in and out both active");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> st_q == sha_pkg::ST_IDLE)
		else $error("no return to idle");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> sts.busy) else $error("done while idle");
endmodule
`default_nettype wire
